FILE: rtl/mrm2_pkg.sv
package mrm2_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  // What the back end does with the value of one queued item
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_WORD = 2'd1,
    OP_TAIL = 2'd2
  } op_t;

  // One classified item between front and back end.
  // For OP_WORD val holds the fully mixed k, for OP_TAIL the masked tail bytes.
  typedef struct packed {
    logic        start;
    logic        last;
    op_t         op;
    logic [31:0] init;
    logic [31:0] val;
  } entry_t;

endpackage

FILE: rtl/mrm2_fifo.sv
module mrm2_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

FILE: rtl/mrm2_front.sv
module mrm2_front #(
  parameter int MID_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [31:0]                    seed,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_start_req,
  input  logic [30:0]                    in_message_length,
  input  logic [31:0]                    in_data_word,
  input  logic [2:0]                     in_word_bytes,
  input  logic                           in_last,
  input  logic [$clog2(MID_DEPTH+1)-1:0] mid_count,
  output logic                           mid_push,
  output mrm2_pkg::entry_t               mid_entry
);
  import mrm2_pkg::*;

  localparam int MCW = $clog2(MID_DEPTH + 1);

  logic           open_r, open_nxt;
  logic           f1_v_r, f2_v_r;
  entry_t         f1_e_r, f1_e_nxt;
  entry_t         f2_e_r, f2_e_nxt;
  logic [MCW:0]   used;
  logic           accept, take;
  logic [31:0]    k_pre;
  logic [31:0]    k_mix;

  // Reserve a queue slot for every item in flight so the pipe never stalls
  assign used    = {1'b0, mid_count} + (MCW + 1)'(f1_v_r) + (MCW + 1)'(f2_v_r);
  assign in_full = (used >= (MCW + 1)'(MID_DEPTH));
  assign accept  = in_push && !in_full;
  // Drop items that arrive with no message open
  assign take    = accept && (in_start_req || open_r);

  assign k_pre = in_data_word * MIX_MUL;

  always_comb begin
    f1_e_nxt.start = in_start_req;
    f1_e_nxt.last  = in_last;
    f1_e_nxt.init  = seed ^ {1'b0, in_message_length};
    f1_e_nxt.op    = OP_TAIL;
    f1_e_nxt.val   = '0;
    if (in_word_bytes inside {[3'd4:3'd7]}) begin
      f1_e_nxt.op  = OP_WORD;
      f1_e_nxt.val = k_pre;
    end else begin
      case (in_word_bytes)
        3'd1:    f1_e_nxt.val = {24'd0, in_data_word[7:0]};
        3'd2:    f1_e_nxt.val = {16'd0, in_data_word[15:0]};
        3'd3:    f1_e_nxt.val = {8'd0, in_data_word[23:0]};
        default: f1_e_nxt.op  = OP_NONE;
      endcase
    end
  end

  assign open_nxt = take ? !in_last : open_r;

  assign k_mix = f1_e_r.val ^ (f1_e_r.val >> MIX_SHIFT);

  always_comb begin
    f2_e_nxt = f1_e_r;
    if (f1_e_r.op == OP_WORD) begin
      f2_e_nxt.val = k_mix * MIX_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
      f1_v_r <= take;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_e_r <= f1_e_nxt;
    f2_e_r <= f2_e_nxt;
  end

  assign mid_push  = f2_v_r;
  assign mid_entry = f2_e_r;

endmodule

FILE: rtl/mrm2_back.sv
module mrm2_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           mid_empty,
  input  mrm2_pkg::entry_t               mid_entry,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output logic [31:0]                    out_data
);
  import mrm2_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic [31:0]  acc_r, acc_nxt;
  logic         av1_v_r, av2_v_r;
  logic [31:0]  av1_r, av2_r;
  logic [OCW:0] used;
  logic [31:0]  h_base, mul_a, prod;

  assign used    = {1'b0, out_count} + (OCW + 1)'(av1_v_r) + (OCW + 1)'(av2_v_r);
  assign mid_pop = !mid_empty && (used < (OCW + 1)'(OUT_DEPTH));

  assign h_base = mid_entry.start ? mid_entry.init : acc_r;
  assign mul_a  = (mid_entry.op == OP_TAIL) ? (h_base ^ mid_entry.val) : h_base;
  assign prod   = mul_a * MIX_MUL;

  always_comb begin
    case (mid_entry.op)
      OP_WORD: acc_nxt = prod ^ mid_entry.val;
      OP_TAIL: acc_nxt = prod;
      default: acc_nxt = h_base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      av1_v_r <= 1'b0;
      av2_v_r <= 1'b0;
    end else begin
      if (mid_pop) begin
        acc_r <= acc_nxt;
      end
      av1_v_r <= mid_pop && mid_entry.last;
      av2_v_r <= av1_v_r;
    end
  end

  // Avalanche: shift-xor, multiply, shift-xor over three stages
  always_ff @(posedge clk) begin
    av1_r <= acc_nxt ^ (acc_nxt >> FIN_SHIFT_A);
    av2_r <= av1_r * MIX_MUL;
  end

  assign out_push = av2_v_r;
  assign out_data = av2_r ^ (av2_r >> FIN_SHIFT_B);

endmodule

FILE: rtl/murmur2_hash_32.sv
// Channel   Direction  Handshake           Payload
// in_*      input      in_push / in_full   start_req, message_length, data_word,
//                                          word_bytes, last
// out_*     output     out_pop / out_empty hash
// cfg_*     input      cfg_valid/cfg_ready seed
//
// One item per cycle sustained while in_full stays low; the accumulator loop in
// the back end holds one multiply and one xor. After its last item transfers,
// a hash passes the second premix stage, the middle queue write, the
// accumulator update with the first avalanche step, the avalanche multiply and
// the output queue write before out_empty goes low.
// Synchronous active-low reset empties both queues and closes any message.
// in_full rises once the middle queue has no slot for the items in flight;
// a stalled out_pop backs up through the output queue to in_full.
module murmur2_hash_32 #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_start_req,
  input  logic [30:0] in_message_length,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_word_bytes,
  input  logic        in_last,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [31:0] out_hash
);
  import mrm2_pkg::*;

  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam int EW  = $bits(entry_t);

  logic [31:0]    seed_r;
  logic           mid_push, mid_pop, mid_empty;
  entry_t         mid_wentry, mid_rentry;
  logic [EW-1:0]  mid_rbits;
  logic [MCW-1:0] mid_count;
  logic           out_push;
  logic [31:0]    out_data;
  logic [OCW-1:0] out_count;

  // Seed register: always ready; the user must write it only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_seed;
    end
  end

  // Front end: accept, drop orphan items, classify and premix full words
  mrm2_front #(
    .MID_DEPTH (MID_DEPTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .seed              (seed_r),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_start_req      (in_start_req),
    .in_message_length (in_message_length),
    .in_data_word      (in_data_word),
    .in_word_bytes     (in_word_bytes),
    .in_last           (in_last),
    .mid_count         (mid_count),
    .mid_push          (mid_push),
    .mid_entry         (mid_wentry)
  );

  // Middle queue decouples the premix pipe from the accumulator
  mrm2_fifo #(
    .WIDTH (EW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wentry),
    .pop   (mid_pop),
    .rdata (mid_rbits),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign mid_rentry = entry_t'(mid_rbits);

  // Back end: fold into the accumulator, avalanche on the last item
  mrm2_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_entry (mid_rentry),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_data)
  );

  // Output queue holds finished hashes until the consumer pops them
  mrm2_fifo #(
    .WIDTH (32),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_data),
    .pop   (out_pop),
    .rdata (out_hash),
    .empty (out_empty),
    .count (out_count)
  );

  // Credit accounting must keep both queues from overflowing
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> (mid_count < MCW'(MID_DEPTH)))
    else $error("middle queue pushed while full");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> (out_count < OCW'(OUT_DEPTH)))
    else $error("output queue pushed while full");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("back end popped an empty middle queue");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (out_empty && mid_empty && !out_push))
    else $error("queues not empty after reset");

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Hash constants for the predictor
  localparam logic [31:0] HASH_MUL   = 32'h5bd1e995;
  localparam int          WORD_SHIFT = 24;
  localparam int          AVAL_A     = 13;
  localparam int          AVAL_B     = 15;

  // Cycles to let pass after the last hash before touching the seed or ending.
  localparam int SETTLE_CYCLES = 12;

  // Whole-run limit in ns (one clock is 2 ns)
  localparam int RUN_LIMIT_NS = 400_000;

  typedef struct packed {
    logic        start;
    logic [30:0] len;
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } hash_item_t;

  // Tracks the hash state seen by the design and holds the hashes still owed.
  class hash_board;
    logic [31:0] seed;
    logic [31:0] acc;
    bit          open;
    logic [31:0] owed_hashes[$];
    int          errors;

    function new();
      seed   = '0;
      acc    = '0;
      open   = 1'b0;
      errors = 0;
    endfunction

    function void set_seed(logic [31:0] value);
      seed = value;
    endfunction

    function int pending();
      return owed_hashes.size();
    endfunction

    // Fold one accepted item into the running hash; queue the digest on last.
    function void note_item(hash_item_t it);
      logic [31:0] h;
      logic [31:0] k;
      logic [31:0] mask;
      if (it.start) begin
        h = seed ^ {1'b0, it.len};
      end else if (open) begin
        h = acc;
      end else begin
        return;
      end
      if (it.nbytes >= 3'd4) begin
        k = it.word * HASH_MUL;
        k = k ^ (k >> WORD_SHIFT);
        k = k * HASH_MUL;
        h = (h * HASH_MUL) ^ k;
      end else if (it.nbytes != 3'd0) begin
        mask = (32'h1 << (8 * int'(it.nbytes))) - 32'h1;
        h = (h ^ (it.word & mask)) * HASH_MUL;
      end
      acc  = h;
      open = !it.last;
      if (it.last) begin
        h = h ^ (h >> AVAL_A);
        h = h * HASH_MUL;
        h = h ^ (h >> AVAL_B);
        owed_hashes.push_back(h);
      end
    endfunction

    function void check_hash(logic [31:0] got);
      logic [31:0] want;
      if (owed_hashes.size() == 0) begin
        $error("hash: expected none, actual %h", got);
        errors++;
        return;
      end
      want = owed_hashes.pop_front();
      if (got !== want) begin
        $error("hash: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_seed;
  logic        in_push;
  logic        in_full;
  logic        in_start_req;
  logic [30:0] in_message_length;
  logic [31:0] in_data_word;
  logic [2:0]  in_word_bytes;
  logic        in_last;
  logic        out_pop;
  logic        out_empty;
  logic [31:0] out_hash;

  hash_board board = new();

  // Idle knobs, in percent per cycle, plus a one-shot receiver hold-off
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int          hold_off      = 0;
  int          items_sent    = 0;

  murmur2_hash_32 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_seed          (cfg_seed),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_start_req      (in_start_req),
    .in_message_length (in_message_length),
    .in_data_word      (in_data_word),
    .in_word_bytes     (in_word_bytes),
    .in_last           (in_last),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_hash          (out_hash)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the design hangs or never delivers a hash
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: check every transfer, then pick next cycle's pop.
  // Signals are read right after the edge, so they hold their pre-edge values.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        board.check_hash(out_hash);
      end
      if (hold_off > 0) begin
        // long hold-off: drop pop so the design backs up into in_full
        hold_off--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  function automatic hash_item_t mk_item(logic start, logic [30:0] len, logic [31:0] word,
                                         logic [2:0] nbytes, logic last);
    hash_item_t it;
    it.start  = start;
    it.len    = len;
    it.word   = word;
    it.nbytes = nbytes;
    it.last   = last;
    return it;
  endfunction

  // Offer one item and hold it until the design takes it. Leave in_push high
  // afterward; the next call either keeps it high or drops it for a gap.
  task automatic push_word(input hash_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push           <= 1'b1;
    in_start_req      <= it.start;
    in_message_length <= it.len;
    in_data_word      <= it.word;
    in_word_bytes     <= it.nbytes;
    in_last           <= it.last;
    do @(posedge clk); while (in_full);
    board.note_item(it);
  endtask

  // Stop offering, wait for every owed hash, then let the pipeline settle.
  task automatic wait_hashes_done();
    in_push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the seed through its own channel; call only while the design is idle.
  task automatic write_seed(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_seed  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_seed(value);
  endtask

  // One message with random content. Mostly well formed; with junk allowed,
  // some are abandoned, carry odd byte counts or are followed by stray items.
  task automatic send_message(input bit allow_junk);
    int unsigned nfull;
    int unsigned tail;
    int unsigned len;
    bit          abandon;
    logic [30:0] len_field;
    hash_item_t  it;
    nfull   = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
    tail    = $urandom_range(3);
    len     = 4 * nfull + tail;
    abandon = allow_junk && ($urandom_range(15) == 0);
    // now and then a length that has nothing to do with the data
    len_field = ($urandom_range(7) == 0) ? 31'($urandom) : 31'(len);
    if (len == 0) begin
      push_word(mk_item(1'b1, len_field, $urandom, 3'd0, !abandon));
      items_sent++;
    end
    for (int i = 0; i < int'(nfull); i++) begin
      it = mk_item(i == 0, len_field, $urandom, 3'd4,
                   (tail == 0) && (i == int'(nfull) - 1) && !abandon);
      if (allow_junk && $urandom_range(9) == 0) begin
        // oversized count (taken as a full word), or a short word mid-message
        it.nbytes = 3'($urandom_range(7));
      end
      push_word(it);
      items_sent++;
    end
    if (tail != 0) begin
      push_word(mk_item(nfull == 0, len_field, $urandom, 3'(tail), !abandon));
      items_sent++;
    end
    if (allow_junk && !abandon && $urandom_range(9) == 0) begin
      // stray item with no message open: the design must ignore it
      push_word(mk_item(1'b0, 31'($urandom), $urandom, 3'($urandom_range(7)),
                        1'($urandom)));
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int count);
    int target;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    target = items_sent + count;
    while (items_sent < target) send_message(1'b1);
  endtask

  task automatic run_directed();
    // stray item right after reset, nothing open: ignored
    push_word(mk_item(1'b0, 31'h7fffffff, 32'hffffffff, 3'd4, 1'b1));
    // empty message
    push_word(mk_item(1'b1, 31'd0, 32'hffffffff, 3'd0, 1'b1));
    // single full word, both data extremes
    push_word(mk_item(1'b1, 31'd4, 32'hffffffff, 3'd4, 1'b1));
    push_word(mk_item(1'b1, 31'd4, 32'h00000000, 3'd4, 1'b1));
    // tails of one to three bytes with junk above them
    push_word(mk_item(1'b1, 31'd1, 32'hffffffff, 3'd1, 1'b1));
    push_word(mk_item(1'b1, 31'd2, 32'hffffffff, 3'd2, 1'b1));
    push_word(mk_item(1'b1, 31'd3, 32'hffffffff, 3'd3, 1'b1));
    // byte counts past four count as a full word
    push_word(mk_item(1'b1, 31'd4, 32'h12345678, 3'd5, 1'b1));
    push_word(mk_item(1'b1, 31'd4, 32'h9abcdef0, 3'd6, 1'b1));
    push_word(mk_item(1'b1, 31'd4, 32'hdeadbeef, 3'd7, 1'b1));
    // multi-word message with the largest length field
    push_word(mk_item(1'b1, 31'h7fffffff, 32'h00000000, 3'd4, 1'b0));
    push_word(mk_item(1'b0, 31'h0, 32'hffffffff, 3'd4, 1'b0));
    push_word(mk_item(1'b0, 31'h0, 32'ha5a5a5a5, 3'd3, 1'b1));
    // restart in the middle of a message: the first one is abandoned
    push_word(mk_item(1'b1, 31'd12, 32'h01020304, 3'd4, 1'b0));
    push_word(mk_item(1'b0, 31'd12, 32'h05060708, 3'd4, 1'b0));
    push_word(mk_item(1'b1, 31'd8, 32'h11223344, 3'd4, 1'b0));
    push_word(mk_item(1'b0, 31'd8, 32'h55667788, 3'd4, 1'b1));
    // short word before the end is folded in as a tail anyway
    push_word(mk_item(1'b1, 31'd10, 32'hcafef00d, 3'd2, 1'b0));
    push_word(mk_item(1'b0, 31'd10, 32'h0badc0de, 3'd4, 1'b0));
    push_word(mk_item(1'b0, 31'd10, 32'h76543210, 3'd0, 1'b0));
    push_word(mk_item(1'b0, 31'd10, 32'hfedcba98, 3'd4, 1'b1));
    // zero length declared, data present: length is not checked
    push_word(mk_item(1'b1, 31'd0, 32'h80000001, 3'd4, 1'b1));
    // item after the message closed: ignored again
    push_word(mk_item(1'b0, 31'd5, 32'h13579bdf, 3'd1, 1'b0));
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_seed          = '0;
    in_push           = 1'b0;
    in_start_req      = 1'b0;
    in_message_length = '0;
    in_data_word      = '0;
    in_word_bytes     = '0;
    in_last           = 1'b0;

    // hold reset, release it once, never again
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs on the reset seed of zero
    run_directed();
    wait_hashes_done();

    // one phase per idle mode, each on its own seed
    write_seed(32'hffffffff);
    run_phase(0, 0, 150);
    wait_hashes_done();
    write_seed($urandom);
    run_phase(52, 0, 150);
    wait_hashes_done();
    write_seed(32'h80000000);
    run_phase(0, 52, 150);
    wait_hashes_done();
    write_seed(32'h00000001);
    run_phase(11, 11, 150);
    wait_hashes_done();

    // back pressure: hold the receiver off while the sender streams short
    // messages without gaps until the design fills and raises in_full
    write_seed(32'h00000000);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_off      = 120;
    repeat (40) begin
      push_word(mk_item(1'b1, 31'($urandom), $urandom, 3'($urandom_range(7)), 1'b1));
      items_sent++;
    end
    // pause the sender until every owed hash has come back
    wait_hashes_done();

    write_seed($urandom);
    run_phase(0, 0, 110);

    // final drain, keep the receiver popping, then report
    pop_stall_pct = 0;
    wait_hashes_done();
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mrm2_pkg.sv
rtl/mrm2_fifo.sv
rtl/mrm2_front.sv
rtl/mrm2_back.sv
rtl/murmur2_hash_32.sv
tb/testbench.sv
